[rtl/prss_pkg.sv]
// ----------------------------------------------------------------------------
// prss_pkg
// Shared constants, codes and types of the priority ready-set scheduler.
// ----------------------------------------------------------------------------
package prss_pkg;

  localparam int NUM_THREADS = 32;
  localparam int TICK_BITS   = 32;
  localparam int PRIO_W      = 6;
  localparam int TICKS_IN_W  = 32;
  localparam int MASK_W      = 32;
  localparam int IDX_W       = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int PIDX_W      = $clog2(NUM_THREADS + 1);
  localparam int CNT_W       = $clog2(NUM_THREADS + 1);
  localparam int Q_DEPTH     = 2;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_DELAY  = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_SWITCH = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_START  = 2'd1,
    ST_IDLE_DELAY = 2'd2,
    ST_ZERO_DELAY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SWEEP,
    BK_REPORT
  } bk_state_e;

  typedef struct packed {
    func_e                 func;
    logic [PRIO_W-1:0]     prio;
    logic                  prio_bad;
    logic [TICK_BITS-1:0]  ticks;
    logic                  ticks_zero;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_req_t;

  typedef struct packed {
    logic busy;
    logic sweeping;
  } bk_stat_t;

endpackage

[rtl/prss_ifs.sv]
// ----------------------------------------------------------------------------
// prss channel interfaces
// Event and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface prss_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic [prss_pkg::PRIO_W-1:0]         priority_req;
  logic [prss_pkg::TICKS_IN_W-1:0]     delay_ticks;

  modport source (output valid, func, priority_req, delay_ticks, input ready);
  modport sink   (input valid, func, priority_req, delay_ticks, output ready);
endinterface

interface prss_out_if;
  logic                            valid;
  logic                            ready;
  logic [prss_pkg::PRIO_W-1:0]     next_thread;
  logic                            switch_pending;
  logic [prss_pkg::MASK_W-1:0]     ready_mask;
  logic [prss_pkg::MASK_W-1:0]     delayed_mask;
  logic [1:0]                      status;

  modport source (output valid, next_thread, switch_pending, ready_mask, delayed_mask,
                  status, input ready);
  modport sink   (input valid, next_thread, switch_pending, ready_mask, delayed_mask,
                  status, output ready);
endinterface

[rtl/prss_front.sv]
// ----------------------------------------------------------------------------
// prss_front
// Accepts event beats, decodes the stateless checks and queues them.
// ----------------------------------------------------------------------------
module prss_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  prss_in_if.sink           in_i,
  output prss_pkg::op_req_t req_o,
  input  logic              pop_i
);

  localparam int QP_W = (prss_pkg::Q_DEPTH > 1) ? $clog2(prss_pkg::Q_DEPTH) : 1;
  localparam int QC_W = $clog2(prss_pkg::Q_DEPTH + 1);

  prss_pkg::op_t   q_mem [prss_pkg::Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0] count_q;
  prss_pkg::op_t   op_in;
  logic            push, pop;

  always_comb begin
    op_in.func       = prss_pkg::func_e'(in_i.func);
    op_in.prio       = in_i.priority_req;
    op_in.prio_bad   = (in_i.priority_req > prss_pkg::PRIO_W'(prss_pkg::NUM_THREADS));
    op_in.ticks      = in_i.delay_ticks[prss_pkg::TICK_BITS-1:0];
    op_in.ticks_zero = (in_i.delay_ticks[prss_pkg::TICK_BITS-1:0] == '0);
  end

  assign in_i.ready = (count_q != QC_W'(prss_pkg::Q_DEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (count_q != '0);
  assign req_o.valid = (count_q != '0);
  assign req_o.op    = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= op_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QP_W'(prss_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QP_W'(prss_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[rtl/prss_back.sv]
// ----------------------------------------------------------------------------
// prss_back
// Executes queued events on the scheduler state and registers the result.
// ----------------------------------------------------------------------------
module prss_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prss_pkg::op_req_t req_i,
  output logic              pop_o,
  output prss_pkg::bk_stat_t stat_o,
  prss_out_if.source        out_o
);

  localparam int N = prss_pkg::NUM_THREADS;

  prss_pkg::bk_state_e state_q, state_d;

  logic [N-1:0]                   ready_q, delayed_q;
  logic [N:0]                     started_q;
  logic [prss_pkg::PRIO_W-1:0]    cur_q, chosen_q;
  logic                           cur_valid_q;
  prss_pkg::status_e              status_q;

  logic [prss_pkg::CNT_W-1:0]     cnt_q;
  logic                           proc_v_q;
  logic [prss_pkg::IDX_W-1:0]     proc_idx_q;

  logic [prss_pkg::TICK_BITS-1:0] tmo_mem [N];
  logic [prss_pkg::TICK_BITS-1:0] rd_q;

  logic                           out_valid_q;
  logic [prss_pkg::PRIO_W-1:0]    out_next_q;
  logic                           out_pend_q;
  logic [N-1:0]                   out_ready_q, out_delayed_q;
  prss_pkg::status_e              out_status_q;

  logic                           out_free, load;
  logic                           sweep_hit, delay_ok;
  logic [prss_pkg::TICK_BITS-1:0] dec;
  logic                           mem_we;
  logic [prss_pkg::IDX_W-1:0]     mem_wa, cur_idx, prio_idx;
  logic [prss_pkg::TICK_BITS-1:0] mem_wd;
  logic [prss_pkg::PIDX_W-1:0]    started_idx;
  logic [prss_pkg::PRIO_W-1:0]    prio_m1, cur_m1, next;
  prss_pkg::op_t                  op;

  assign op          = req_i.op;
  assign out_free    = !out_valid_q || out_o.ready;
  assign dec         = rd_q - 1'b1;
  assign sweep_hit   = proc_v_q && delayed_q[proc_idx_q];
  assign delay_ok    = cur_valid_q && (cur_q != '0) && !op.ticks_zero;
  assign prio_m1     = op.prio - 1'b1;
  assign cur_m1      = cur_q - 1'b1;
  assign prio_idx    = prio_m1[prss_pkg::IDX_W-1:0];
  assign cur_idx     = cur_m1[prss_pkg::IDX_W-1:0];
  assign started_idx = op.prio[prss_pkg::PIDX_W-1:0];

  always_comb begin
    next = '0;
    for (int i = 0; i < N; i++) begin
      if (ready_q[i]) begin
        next = prss_pkg::PRIO_W'(i + 1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    unique case (state_q)
      prss_pkg::BK_IDLE: begin
        if (req_i.valid) begin
          pop_o   = 1'b1;
          state_d = (op.func == prss_pkg::FUNC_TICK) ? prss_pkg::BK_SWEEP
                                                     : prss_pkg::BK_REPORT;
        end
      end
      prss_pkg::BK_SWEEP: begin
        if (cnt_q == prss_pkg::CNT_W'(N)) begin
          state_d = prss_pkg::BK_REPORT;
        end
      end
      prss_pkg::BK_REPORT: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = prss_pkg::BK_IDLE;
        end
      end
      default: state_d = prss_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    if (state_q == prss_pkg::BK_SWEEP) begin
      mem_we = sweep_hit;
      mem_wa = proc_idx_q;
      mem_wd = dec;
    end else begin
      mem_we = pop_o && (op.func == prss_pkg::FUNC_DELAY) && delay_ok;
      mem_wa = cur_idx;
      mem_wd = op.ticks;
    end
  end

  // timeout store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tmo_mem[mem_wa] <= mem_wd;
    end
    rd_q <= tmo_mem[cnt_q[prss_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prss_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q     <= '0;
      delayed_q   <= '0;
      started_q   <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      chosen_q    <= '0;
      status_q    <= prss_pkg::ST_OK;
      cnt_q       <= '0;
      proc_v_q    <= 1'b0;
      proc_idx_q  <= '0;
    end else begin
      if (pop_o) begin
        case (op.func)
          prss_pkg::FUNC_START: begin
            if (op.prio_bad || started_q[started_idx]) begin
              status_q <= prss_pkg::ST_BAD_START;
            end else begin
              status_q <= prss_pkg::ST_OK;
              started_q[started_idx] <= 1'b1;
              if (op.prio != '0) begin
                ready_q[prio_idx] <= 1'b1;
              end
            end
          end
          prss_pkg::FUNC_DELAY: begin
            if (!cur_valid_q || (cur_q == '0)) begin
              status_q <= prss_pkg::ST_IDLE_DELAY;
            end else if (op.ticks_zero) begin
              status_q <= prss_pkg::ST_ZERO_DELAY;
            end else begin
              status_q           <= prss_pkg::ST_OK;
              ready_q[cur_idx]   <= 1'b0;
              delayed_q[cur_idx] <= 1'b1;
            end
          end
          prss_pkg::FUNC_TICK: begin
            status_q <= prss_pkg::ST_OK;
            cnt_q    <= '0;
            proc_v_q <= 1'b0;
          end
          default: begin
            status_q    <= prss_pkg::ST_OK;
            cur_q       <= chosen_q;
            cur_valid_q <= 1'b1;
          end
        endcase
      end
      if (state_q == prss_pkg::BK_SWEEP) begin
        if (sweep_hit && (dec == '0)) begin
          ready_q[proc_idx_q]   <= 1'b1;
          delayed_q[proc_idx_q] <= 1'b0;
        end
        if (cnt_q != prss_pkg::CNT_W'(N)) begin
          proc_v_q   <= 1'b1;
          proc_idx_q <= cnt_q[prss_pkg::IDX_W-1:0];
          cnt_q      <= cnt_q + 1'b1;
        end else begin
          proc_v_q <= 1'b0;
        end
      end
      if (load) begin
        chosen_q <= next;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_next_q    <= next;
      out_pend_q    <= !cur_valid_q || (next != cur_q);
      out_ready_q   <= ready_q;
      out_delayed_q <= delayed_q;
      out_status_q  <= status_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.next_thread    = out_next_q;
  assign out_o.switch_pending = out_pend_q;
  assign out_o.ready_mask     = prss_pkg::MASK_W'(out_ready_q);
  assign out_o.delayed_mask   = prss_pkg::MASK_W'(out_delayed_q);
  assign out_o.status         = out_status_q;

  assign stat_o.busy     = (state_q != prss_pkg::BK_IDLE);
  assign stat_o.sweeping = (state_q == prss_pkg::BK_SWEEP);

endmodule

[rtl/priority_ready_set_scheduler.sv]
// ----------------------------------------------------------------------------
// priority_ready_set_scheduler
// Bitmap priority scheduler for up to 32 threads plus idle, with delay
// timeouts counted down by tick events.
// ----------------------------------------------------------------------------
// in_i carries one event per beat (start, delay, tick, switch done); out_o
// returns one result beat per event, in order: highest ready priority,
// switch pending flag, ready and delayed masks and a status code.
// Events enter a two-deep queue, so the input keeps accepting while the
// executing side works or a result waits to be taken.
// Start, delay and switch done pass from the idle state to the report state
// of the executing side, which takes no new event until it is back in idle.
// A tick walks the timeout memory one entry per cycle through its single
// read port.
// Reset clears all masks, the started set and the running thread; the
// timeout memory needs no clearing as only delayed entries are used.
// A stalled receiver holds the result register; the next event is still
// executed and waits for the result register before reporting, and the
// queue fills, then drops in_i.ready.
// ----------------------------------------------------------------------------
module priority_ready_set_scheduler (
  input  logic       clk_i,
  input  logic       rst_ni,
  prss_in_if.sink    in_i,
  prss_out_if.source out_o
);

  prss_pkg::op_req_t  req;
  logic               pop;
  prss_pkg::bk_stat_t bk_stat;

  prss_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .req_o  (req),
    .pop_i  (pop)
  );

  prss_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .pop_o  (pop),
    .stat_o (bk_stat),
    .out_o  (out_o)
  );

`ifndef ASSERT_OFF
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> req.valid)
    else $error("pop from empty queue");

  a_pop_makes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> bk_stat.busy)
    else $error("back side not busy after taking an event");

  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> req.valid)
    else $error("accepted beat missing from queue");

  a_no_result_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bk_stat.sweeping && !out_o.valid) |=> !out_o.valid)
    else $error("result produced during timeout sweep");
`endif

endmodule
